// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define SBM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked during reset too.
`define SBM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/sbm_pkg.sv
// Shared types and constants of the same-signal blob merge block.
// Depends on nothing.
package sbm_pkg;

    localparam int COORD_W = 16;
    localparam int ID_W    = 8;
    localparam int CNT_W   = 6;
    localparam int SUM_W   = 21;
    localparam int DIST_W  = 16;
    localparam int SQ_W    = 2 * COORD_W;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [ID_W-1:0]    id;
    } t_point;

    typedef struct packed {
        logic load;
        logic seed_inc;
        logic seed_start;
        logic latch_sig;
        logic pop;
        logic take_cur;
        logic div_start;
        logic emit;
        logic flush;
    } t_cmd;

    typedef struct packed {
        logic seed_end;
        logic seed_merged;
        logic stack_empty;
        logic scan_done;
        logic div_done;
    } t_stat;

endpackage

// File: rtl/sbm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module sbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/sbm_ctrl.sv
// Controller: sequences load, flood fill, division and result output.
// Depends on sbm_pkg.
module sbm_ctrl
    import sbm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  logic  i_last_point,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SEED  = 9'b000000010,
        S_SIG   = 9'b000000100,
        S_POP   = 9'b000001000,
        S_CUR   = 9'b000010000,
        S_SCAN  = 9'b000100000,
        S_DIV   = 9'b001000000,
        S_EMIT  = 9'b010000000,
        S_FLUSH = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_last_point) n_state = S_SEED;
                end
            end
            S_SEED: begin
                priority if (i_stat.seed_end) begin
                    n_state = S_FLUSH;
                end else if (i_stat.seed_merged) begin
                    o_cmd.seed_inc = 1'b1;
                end else begin
                    o_cmd.seed_start = 1'b1;
                    n_state = S_SIG;
                end
            end
            S_SIG: begin
                o_cmd.latch_sig = 1'b1;
                n_state = S_POP;
            end
            S_POP: begin
                if (i_stat.stack_empty) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state = S_CUR;
                end
            end
            S_CUR: begin
                o_cmd.take_cur = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.scan_done) n_state = S_POP;
            end
            S_DIV: begin
                if (i_stat.div_done) n_state = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit     = 1'b1;
                o_cmd.seed_inc = 1'b1;
                n_state = S_SEED;
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

// File: rtl/sbm_dp.sv
// Datapath: point store, merged flags, pending stack, distance pipe,
// centroid dividers and output registers. Depends on sbm_pkg, sbm_ram.
module sbm_dp
    import sbm_pkg::*;
#(
    parameter int MAX_POINTS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic               i_cfg_we,
    input  logic [DIST_W-1:0]  i_cfg_wdata,
    input  logic [COORD_W-1:0] i_point_x,
    input  logic [COORD_W-1:0] i_point_y,
    input  logic [ID_W-1:0]    i_signal_id,
    output t_stat              o_stat,
    output logic               o_strobe,
    output logic [COORD_W-1:0] o_centroid_x,
    output logic [COORD_W-1:0] o_centroid_y,
    output logic [ID_W-1:0]    o_cluster_signal,
    output logic [CNT_W-1:0]   o_member_count,
    output logic               o_dropped_points,
    output logic               o_last_cluster
);
    localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int DCW = $clog2(SUM_W + 1);
    localparam int PW = $bits(t_point);

    // set bookkeeping
    logic [CW-1:0]     r_loaded, r_seed, r_depth, r_cand;
    logic              r_ovf;
    logic [ID_W-1:0]   r_sig;
    logic [MAX_POINTS-1:0] r_merged;
    logic [IW-1:0]     r_stack [MAX_POINTS];
    logic [COORD_W-1:0] r_cur_x, r_cur_y;
    logic [SUM_W-1:0]  r_sum_x, r_sum_y;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIST_W-1:0] r_md;
    logic [SQ_W-1:0]   r_limit;

    // scan pipe
    logic              r_scan_on, r_vb, r_vc, r_idm;
    logic [IW-1:0]     r_cand_b, r_cand_c;
    logic [SQ_W-1:0]   r_dx2, r_dy2;

    // divider
    logic [DCW-1:0]    r_dcnt;
    logic [SUM_W-1:0]  r_qx, r_qy;
    logic [CNT_W-1:0]  r_rx, r_ry;

    // pending and output result
    logic               r_pv;
    logic [COORD_W-1:0] r_px, r_py;
    logic [ID_W-1:0]    r_psig;
    logic [CNT_W-1:0]   r_pcnt;
    logic               r_pdrop;
    logic               r_ov;
    logic [COORD_W-1:0] r_ox, r_oy;
    logic [ID_W-1:0]    r_osig;
    logic [CNT_W-1:0]   r_ocnt;
    logic               r_odrop, r_olast;

    t_point           w_wr, w_rd;
    logic [IW-1:0]    w_raddr, w_top;
    logic             w_can_load, w_join;
    logic [SQ_W:0]    w_d2;
    logic [COORD_W-1:0] w_dx, w_dy;
    logic [CNT_W:0]   w_tx, w_ty;

    assign w_can_load = (r_loaded < CW'(MAX_POINTS));
    assign w_wr       = '{x: i_point_x, y: i_point_y, id: i_signal_id};
    assign w_top      = r_stack[IW'(r_depth - 1'b1)];

    always_comb begin
        priority if (i_cmd.seed_start) w_raddr = r_seed[IW-1:0];
        else if (i_cmd.pop)            w_raddr = w_top;
        else                           w_raddr = r_cand[IW-1:0];
    end

    sbm_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load && w_can_load),
        .i_waddr (r_loaded[IW-1:0]),
        .i_wdata (w_wr),
        .i_raddr (w_raddr),
        .o_rdata (w_rd)
    );

    assign w_dx = (w_rd.x > r_cur_x) ? w_rd.x - r_cur_x : r_cur_x - w_rd.x;
    assign w_dy = (w_rd.y > r_cur_y) ? w_rd.y - r_cur_y : r_cur_y - w_rd.y;
    assign w_d2 = {1'b0, r_dx2} + {1'b0, r_dy2};
    assign w_join = r_vc && !r_merged[r_cand_c] && r_idm && (w_d2 < {1'b0, r_limit});

    // one restoring step per cycle
    assign w_tx = {r_rx, r_qx[SUM_W-1]};
    assign w_ty = {r_ry, r_qy[SUM_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded  <= '0;
            r_seed    <= '0;
            r_depth   <= '0;
            r_cand    <= '0;
            r_ovf     <= 1'b0;
            r_merged  <= '0;
            r_md      <= '0;
            r_scan_on <= 1'b0;
            r_vb      <= 1'b0;
            r_vc      <= 1'b0;
            r_dcnt    <= '0;
            r_pv      <= 1'b0;
            r_ov      <= 1'b0;
        end else begin
            if (i_cfg_we) r_md <= i_cfg_wdata;

            if (i_cmd.load) begin
                if (w_can_load) r_loaded <= r_loaded + 1'b1;
                else            r_ovf    <= 1'b1;
            end

            if (i_cmd.seed_inc) r_seed <= r_seed + 1'b1;

            if (i_cmd.seed_start) begin
                r_merged[r_seed[IW-1:0]] <= 1'b1;
                r_stack[0] <= r_seed[IW-1:0];
                r_depth    <= CW'(1);
                r_sum_x    <= '0;
                r_sum_y    <= '0;
                r_cnt      <= '0;
            end

            if (i_cmd.latch_sig) r_sig <= w_rd.id;
            if (i_cmd.pop) r_depth <= r_depth - 1'b1;

            if (i_cmd.take_cur) begin
                r_cur_x   <= w_rd.x;
                r_cur_y   <= w_rd.y;
                r_sum_x   <= r_sum_x + SUM_W'(w_rd.x);
                r_sum_y   <= r_sum_y + SUM_W'(w_rd.y);
                r_cnt     <= r_cnt + 1'b1;
                r_cand    <= '0;
                r_scan_on <= 1'b1;
            end

            // stage A: issue candidate read
            r_vb <= r_scan_on;
            if (r_scan_on) begin
                r_cand_b  <= r_cand[IW-1:0];
                r_cand    <= r_cand + 1'b1;
                r_scan_on <= (r_cand + 1'b1 < r_loaded);
            end
            // stage B: squares and id match
            r_vc     <= r_vb;
            r_cand_c <= r_cand_b;
            r_dx2    <= w_dx * w_dx;
            r_dy2    <= w_dy * w_dy;
            r_idm    <= (w_rd.id == r_sig);
            // stage C: join and push
            if (w_join) begin
                r_merged[r_cand_c] <= 1'b1;
                if (r_depth < CW'(MAX_POINTS)) begin
                    r_stack[r_depth[IW-1:0]] <= r_cand_c;
                    r_depth <= r_depth + 1'b1;
                end
            end

            if (i_cmd.div_start) begin
                r_qx   <= r_sum_x + SUM_W'(r_cnt >> 1);
                r_qy   <= r_sum_y + SUM_W'(r_cnt >> 1);
                r_rx   <= '0;
                r_ry   <= '0;
                r_dcnt <= DCW'(SUM_W);
            end else if (r_dcnt != '0) begin
                r_dcnt <= r_dcnt - 1'b1;
                if (w_tx >= {1'b0, r_cnt}) begin
                    r_rx <= CNT_W'(w_tx - {1'b0, r_cnt});
                    r_qx <= {r_qx[SUM_W-2:0], 1'b1};
                end else begin
                    r_rx <= w_tx[CNT_W-1:0];
                    r_qx <= {r_qx[SUM_W-2:0], 1'b0};
                end
                if (w_ty >= {1'b0, r_cnt}) begin
                    r_ry <= CNT_W'(w_ty - {1'b0, r_cnt});
                    r_qy <= {r_qy[SUM_W-2:0], 1'b1};
                end else begin
                    r_ry <= w_ty[CNT_W-1:0];
                    r_qy <= {r_qy[SUM_W-2:0], 1'b0};
                end
            end

            // one result is held back so the final one can be marked
            r_ov <= 1'b0;
            if (i_cmd.emit) begin
                r_ov    <= r_pv;
                r_ox    <= r_px;
                r_oy    <= r_py;
                r_osig  <= r_psig;
                r_ocnt  <= r_pcnt;
                r_odrop <= r_pdrop;
                r_olast <= 1'b0;
                r_pv    <= 1'b1;
                r_px    <= r_qx[COORD_W-1:0];
                r_py    <= r_qy[COORD_W-1:0];
                r_psig  <= r_sig;
                r_pcnt  <= r_cnt;
                r_pdrop <= r_ovf;
            end
            if (i_cmd.flush) begin
                r_ov     <= r_pv;
                r_ox     <= r_px;
                r_oy     <= r_py;
                r_osig   <= r_psig;
                r_ocnt   <= r_pcnt;
                r_odrop  <= r_pdrop;
                r_olast  <= 1'b1;
                r_pv     <= 1'b0;
                r_loaded <= '0;
                r_seed   <= '0;
                r_ovf    <= 1'b0;
                r_merged <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_limit <= r_md * r_md;
    end

    assign o_stat.seed_end    = (r_seed >= r_loaded);
    assign o_stat.seed_merged = (r_seed < r_loaded) ? r_merged[r_seed[IW-1:0]] : 1'b0;
    assign o_stat.stack_empty = (r_depth == '0);
    assign o_stat.scan_done   = !r_scan_on && !r_vb && !r_vc;
    assign o_stat.div_done    = (r_dcnt == '0);

    assign o_strobe         = r_ov;
    assign o_centroid_x     = r_ox;
    assign o_centroid_y     = r_oy;
    assign o_cluster_signal = r_osig;
    assign o_member_count   = r_ocnt;
    assign o_dropped_points = r_odrop;
    assign o_last_cluster   = r_olast;
endmodule

// File: rtl/same_signal_blob_merge_core.sv
// Input: a point is taken while start is high in idle; the closing point starts clustering.
// Clustering: each popped point scans the loaded points, one candidate per cycle
// through the single store read port; each component then runs a 21-step divider.
// Already merged seeds are skipped, and a flush closes the set.
// Results leave one component late; the final one follows the set's last seed.
// Reset: synchronous active low; clears the register, set state and output strobe.
module same_signal_blob_merge_core
    import sbm_pkg::*;
#(
    parameter int MAX_POINTS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [DIST_W-1:0]  i_cfg_wdata,
    input  logic [COORD_W-1:0] i_point_x,
    input  logic [COORD_W-1:0] i_point_y,
    input  logic [ID_W-1:0]    i_signal_id,
    input  logic               i_last_point,
    output logic               o_strobe,
    output logic [COORD_W-1:0] o_centroid_x,
    output logic [COORD_W-1:0] o_centroid_y,
    output logic [ID_W-1:0]    o_cluster_signal,
    output logic [CNT_W-1:0]   o_member_count,
    output logic               o_dropped_points,
    output logic               o_last_cluster
);
    t_cmd  w_cmd;
    t_stat w_stat;

    sbm_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_last_point (i_last_point),
        .i_stat       (w_stat),
        .o_cmd        (w_cmd),
        .o_busy       (busy)
    );

    sbm_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_point_x        (i_point_x),
        .i_point_y        (i_point_y),
        .i_signal_id      (i_signal_id),
        .o_stat           (w_stat),
        .o_strobe         (o_strobe),
        .o_centroid_x     (o_centroid_x),
        .o_centroid_y     (o_centroid_y),
        .o_cluster_signal (o_cluster_signal),
        .o_member_count   (o_member_count),
        .o_dropped_points (o_dropped_points),
        .o_last_cluster   (o_last_cluster)
    );
endmodule

// File: rtl/sbm_checker.sv
// Port-level checks of the blob merge core, bound to the top level.
// Depends on sbm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module sbm_checker
    import sbm_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             busy,
    input logic             o_strobe,
    input logic [CNT_W-1:0] o_member_count,
    input logic             o_last_cluster
);
    `SBM_ASSERT_ALWAYS(a_rst_quiet, !i_rst_n |=> !o_strobe, "strobe after reset")
    `SBM_ASSERT(a_count_nz, o_strobe |-> o_member_count != '0, "empty component")
    `SBM_ASSERT(a_last_idle, o_strobe && o_last_cluster |-> !busy, "final item while busy")
    `SBM_ASSERT(a_mid_busy, o_strobe && !o_last_cluster |-> busy, "early item while idle")
    `SBM_ASSERT(a_spaced, o_strobe |=> !o_strobe, "items back to back")
endmodule

bind same_signal_blob_merge_core sbm_checker u_sbm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .busy           (busy),
    .o_strobe       (o_strobe),
    .o_member_count (o_member_count),
    .o_last_cluster (o_last_cluster)
);
